// File: rtl/core/osms_pkg.sv
// Shared constants, types and codes for the omega statistic maximum search.
`default_nettype none
package osms_pkg;

  localparam int SNP_INDEX_BITS = 20;
  localparam int SUM_BITS       = 40;
  localparam int FRAC_BITS      = 16;
  localparam int OFFSET_BITS    = 32;
  localparam int TOL_BITS       = 20;
  localparam int CFG_ADDR_BITS  = 2;
  localparam int CFG_DATA_BITS  = 32;

  localparam logic [CFG_ADDR_BITS-1:0] REG_DENOM_OFFSET = 2'd0;
  localparam logic [CFG_ADDR_BITS-1:0] REG_BORDER_TOL   = 2'd1;

  localparam logic [OFFSET_BITS-1:0] OFFSET_RESET = 32'd1;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_MUL_K,
    OP_MUL_M,
    OP_MUL_KM,
    OP_SAT,
    OP_DIV_NUM,
    OP_DIV_Q,
    OP_DEN,
    OP_DIV_OMEGA,
    OP_UPDATE,
    OP_EMIT
  } op_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_FILT,
    S_MUL_M,
    S_MUL_KM,
    S_CHECK,
    S_DNUM,
    S_DNUM_W,
    S_DQ,
    S_DQ_W,
    S_DEN,
    S_DOM,
    S_DOM_W,
    S_UPDATE,
    S_EMIT
  } state_t;

  typedef struct packed {
    op_t op;
  } cmd_t;

  typedef struct packed {
    logic keep;
    logic last;
    logic degenerate;
    logic div_done;
    logic div_busy;
    logic out_free;
  } status_t;

endpackage
`default_nettype wire

// File: rtl/core/osms_div.sv
// Restoring radix-2 divider, one quotient bit per cycle.
`default_nettype none
module osms_div #(
  parameter int NDW = 57,
  parameter int DSW = 41
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           start,
  input  wire logic [NDW-1:0] dividend,
  input  wire logic [DSW-1:0] divisor,
  output logic                busy,
  output logic                done,
  output logic [NDW-1:0]      quotient
);

  localparam int CW = $clog2(NDW + 1);

  logic           busy_r, busy_nxt;
  logic           done_r, done_nxt;
  logic [CW-1:0]  cnt_r, cnt_nxt;
  logic [DSW:0]   rem_r, rem_nxt;
  logic [NDW-1:0] quo_r, quo_nxt;
  logic [DSW-1:0] dsr_r, dsr_nxt;
  logic [DSW:0]   rem_sh;
  logic           fits;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dsr_nxt  = dsr_r;
    rem_sh   = {rem_r[DSW-1:0], quo_r[NDW-1]};
    fits     = rem_sh >= {1'b0, dsr_r};
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rem_nxt  = '0;
      quo_nxt  = dividend;
      dsr_nxt  = divisor;
    end else if (busy_r) begin
      rem_nxt = fits ? rem_sh - {1'b0, dsr_r} : rem_sh;
      quo_nxt = {quo_r[NDW-2:0], fits};
      cnt_nxt = cnt_r + CW'(1);
      if (cnt_r == CW'(NDW - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dsr_r <= dsr_nxt;
  end

  assign busy     = busy_r;
  assign done     = done_r;
  assign quotient = quo_r;

  a_done_ends_busy: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> !busy_r && $past(busy_r))
    else $error("divider done without a run");

endmodule
`default_nettype wire

// File: rtl/core/osms_datapath.sv
// Datapath: config registers, multiplier, divider, running maximum, output stage.
`default_nettype none
module osms_datapath #(
  parameter int SNP_INDEX_BITS = osms_pkg::SNP_INDEX_BITS,
  parameter int SUM_BITS       = osms_pkg::SUM_BITS
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire osms_pkg::cmd_t                     cmd,
  output osms_pkg::status_t                       sts,
  input  wire logic                               cfg_wr_en,
  input  wire logic [osms_pkg::CFG_ADDR_BITS-1:0] cfg_addr,
  input  wire logic [osms_pkg::CFG_DATA_BITS-1:0] cfg_wdata,
  input  wire logic [SUM_BITS-1:0]                left_sum,
  input  wire logic [SUM_BITS-1:0]                right_sum,
  input  wire logic [SUM_BITS-1:0]                total_sum,
  input  wire logic [SNP_INDEX_BITS-1:0]          left_snp,
  input  wire logic [SNP_INDEX_BITS-1:0]          center_snp,
  input  wire logic [SNP_INDEX_BITS-1:0]          right_snp,
  input  wire logic                               last_pair,
  output logic                                    out_valid,
  input  wire logic                               out_ready,
  output logic [SUM_BITS-1:0]                     max_omega,
  output logic [SNP_INDEX_BITS-1:0]               best_left_snp,
  output logic [SNP_INDEX_BITS-1:0]               best_right_snp,
  output logic                                    saturated
);

  localparam int NW   = SNP_INDEX_BITS;
  localparam int SW   = SUM_BITS;
  localparam int OB   = osms_pkg::OFFSET_BITS;
  localparam int TB   = osms_pkg::TOL_BITS;
  localparam int FB   = osms_pkg::FRAC_BITS;
  localparam int NUMW = SW + 1;
  localparam int PW   = 2 * NW;
  localparam int DW   = ((SW > OB) ? SW : OB) + 1;
  localparam int DVW  = NUMW + FB;
  localparam int DSW  = (PW > DW) ? PW : DW;
  localparam int FW   = ((NW > TB) ? NW : TB) + 3;

  logic [OB-1:0]   offset_r;
  logic [TB-1:0]   tol_r;
  logic [NW-1:0]   left_r, center_r, right_r, k_r, m_r;
  logic [SW-1:0]   ts_r;
  logic [NUMW-1:0] sum_r;
  logic            last_r;
  logic [PW-1:0]   kk_r, mm_r, km_r, pairs_r;
  logic [NUMW-1:0] num_r;
  logic            num_ovf_r;
  logic [SW-1:0]   q_r;
  logic [DW-1:0]   den_r;
  logic [SW-1:0]   omega_r;
  logic            omega_ovf_r;
  logic            sat_r;
  osms_pkg::op_t   div_op_r;
  logic [SW-1:0]   best_val_r;
  logic [NW-1:0]   best_l_r, best_r_r;
  logic            sat_seen_r;
  logic            out_valid_r;
  logic [SW-1:0]   out_omega_r;
  logic [NW-1:0]   out_l_r, out_r_r;
  logic            out_sat_r;

  logic [NW-1:0]   mul_a, mul_b;
  logic [PW-1:0]   prod;
  logic [SW-1:0]   diff;
  logic [DW-1:0]   den_full;
  logic            div_start, div_busy, div_done;
  logic [DVW-1:0]  div_dvd, div_q;
  logic [DSW-1:0]  div_dsr;
  logic            sat_all;
  logic [SW-1:0]   omega_val;
  logic signed [FW-1:0] c_s, l_s, r_s, t_s, mirror;
  logic            keep;

  // border filter around the mirrored position
  always_comb begin
    c_s    = $signed(FW'(center_r));
    l_s    = $signed(FW'(left_r));
    r_s    = $signed(FW'(right_r));
    t_s    = $signed(FW'(tol_r));
    mirror = (c_s <<< 1) - l_s + $signed(FW'(1));
    keep   = (tol_r == '0) || ((r_s >= mirror - t_s) && (r_s <= mirror + t_s));
  end

  always_comb begin
    unique case (cmd.op)
      osms_pkg::OP_MUL_K: begin
        mul_a = k_r;
        mul_b = k_r - NW'(1);
      end
      osms_pkg::OP_MUL_M: begin
        mul_a = m_r;
        mul_b = m_r - NW'(1);
      end
      default: begin
        mul_a = k_r;
        mul_b = m_r;
      end
    endcase
    prod = PW'(mul_a) * PW'(mul_b);
  end

  always_comb begin
    diff      = (sum_r > NUMW'(ts_r)) ? '0 : SW'(NUMW'(ts_r) - sum_r);
    den_full  = DW'(q_r) + DW'(offset_r);
    div_start = 1'b1;
    unique case (cmd.op)
      osms_pkg::OP_DIV_NUM: begin
        div_dvd = DVW'(sum_r);
        div_dsr = DSW'(pairs_r);
      end
      osms_pkg::OP_DIV_Q: begin
        div_dvd = DVW'(diff);
        div_dsr = DSW'(km_r);
      end
      osms_pkg::OP_DIV_OMEGA: begin
        div_dvd = {num_r, {FB{1'b0}}};
        div_dsr = DSW'(den_r);
      end
      default: begin
        div_start = 1'b0;
        div_dvd   = DVW'(sum_r);
        div_dsr   = DSW'(pairs_r);
      end
    endcase
    sat_all   = sat_r || num_ovf_r || (den_r == '0) || omega_ovf_r;
    omega_val = sat_all ? {SW{1'b1}} : omega_r;
  end

  osms_div #(
    .NDW(DVW),
    .DSW(DSW)
  ) u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (div_start),
    .dividend(div_dvd),
    .divisor (div_dsr),
    .busy    (div_busy),
    .done    (div_done),
    .quotient(div_q)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      offset_r    <= osms_pkg::OFFSET_RESET;
      tol_r       <= '0;
      best_val_r  <= '0;
      best_l_r    <= '0;
      best_r_r    <= '0;
      sat_seen_r  <= 1'b0;
      out_valid_r <= 1'b0;
      div_op_r    <= osms_pkg::OP_NONE;
    end else begin
      if (cfg_wr_en) begin
        unique case (cfg_addr)
          osms_pkg::REG_DENOM_OFFSET: offset_r <= cfg_wdata[OB-1:0];
          osms_pkg::REG_BORDER_TOL:   tol_r    <= cfg_wdata[TB-1:0];
          default: ;
        endcase
      end
      if (out_valid_r && out_ready && cmd.op != osms_pkg::OP_EMIT) begin
        out_valid_r <= 1'b0;
      end
      if (div_start) begin
        div_op_r <= cmd.op;
      end
      unique case (cmd.op)
        osms_pkg::OP_UPDATE: begin
          sat_seen_r <= sat_seen_r | sat_all;
          if (omega_val > best_val_r) begin
            best_val_r <= omega_val;
            best_l_r   <= left_r;
            best_r_r   <= right_r;
          end
        end
        osms_pkg::OP_EMIT: begin
          out_valid_r <= 1'b1;
          best_val_r  <= '0;
          best_l_r    <= '0;
          best_r_r    <= '0;
          sat_seen_r  <= 1'b0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (cmd.op)
      osms_pkg::OP_LOAD: begin
        left_r      <= left_snp;
        center_r    <= center_snp;
        right_r     <= right_snp;
        k_r         <= center_snp - left_snp + NW'(1);
        m_r         <= right_snp - center_snp;
        ts_r        <= total_sum;
        sum_r       <= NUMW'(left_sum) + NUMW'(right_sum);
        last_r      <= last_pair;
        sat_r       <= 1'b0;
        num_ovf_r   <= 1'b0;
        omega_ovf_r <= 1'b0;
      end
      osms_pkg::OP_MUL_K:  kk_r <= prod;
      osms_pkg::OP_MUL_M:  mm_r <= prod;
      osms_pkg::OP_MUL_KM: begin
        km_r    <= prod;
        pairs_r <= (kk_r >> 1) + (mm_r >> 1);
      end
      osms_pkg::OP_SAT:    sat_r <= 1'b1;
      osms_pkg::OP_DEN: begin
        if ((DW == 65) && den_full[DW-1]) begin
          den_r <= DW'({(DW-1){1'b1}});
        end else begin
          den_r <= den_full;
        end
      end
      osms_pkg::OP_EMIT: begin
        out_omega_r <= best_val_r;
        out_l_r     <= best_l_r;
        out_r_r     <= best_r_r;
        out_sat_r   <= sat_seen_r;
      end
      default: ;
    endcase
    if (div_done) begin
      unique case (div_op_r)
        osms_pkg::OP_DIV_NUM: begin
          num_r     <= div_q[NUMW-1:0];
          num_ovf_r <= (NUMW == 65) ? div_q[NUMW-1] : 1'b0;
        end
        osms_pkg::OP_DIV_Q: q_r <= div_q[SW-1:0];
        osms_pkg::OP_DIV_OMEGA: begin
          omega_r     <= div_q[SW-1:0];
          omega_ovf_r <= |div_q[DVW-1:SW];
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    sts.keep       = keep;
    sts.last       = last_r;
    sts.degenerate = (pairs_r == '0) || (km_r == '0);
    sts.div_done   = div_done;
    sts.div_busy   = div_busy;
    sts.out_free   = !out_valid_r || out_ready;
  end

  assign out_valid      = out_valid_r;
  assign max_omega      = out_omega_r;
  assign best_left_snp  = out_l_r;
  assign best_right_snp = out_r_r;
  assign saturated      = out_sat_r;

  a_emit_clears: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.op == osms_pkg::OP_EMIT |=> best_val_r == '0 && !sat_seen_r && out_valid_r)
    else $error("run state not cleared on emit");
  a_best_zero_idx: assert property (@(posedge clk) disable iff (!rst_n)
    best_val_r == '0 |-> best_l_r == '0 && best_r_r == '0)
    else $error("indices recorded without a maximum");

endmodule
`default_nettype wire

// File: rtl/core/osms_ctrl.sv
// Controller state machine sequencing the datapath for one item at a time.
`default_nettype none
module osms_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire osms_pkg::status_t sts,
  output osms_pkg::cmd_t         cmd
);

  osms_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= osms_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd.op    = osms_pkg::OP_NONE;
    in_ready  = 1'b0;
    unique case (state_r)
      osms_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.op    = osms_pkg::OP_LOAD;
          state_nxt = osms_pkg::S_FILT;
        end
      end
      osms_pkg::S_FILT: begin
        if (sts.keep) begin
          cmd.op    = osms_pkg::OP_MUL_K;
          state_nxt = osms_pkg::S_MUL_M;
        end else begin
          state_nxt = sts.last ? osms_pkg::S_EMIT : osms_pkg::S_IDLE;
        end
      end
      osms_pkg::S_MUL_M: begin
        cmd.op    = osms_pkg::OP_MUL_M;
        state_nxt = osms_pkg::S_MUL_KM;
      end
      osms_pkg::S_MUL_KM: begin
        cmd.op    = osms_pkg::OP_MUL_KM;
        state_nxt = osms_pkg::S_CHECK;
      end
      osms_pkg::S_CHECK: begin
        if (sts.degenerate) begin
          cmd.op    = osms_pkg::OP_SAT;
          state_nxt = osms_pkg::S_UPDATE;
        end else begin
          state_nxt = osms_pkg::S_DNUM;
        end
      end
      osms_pkg::S_DNUM: begin
        cmd.op    = osms_pkg::OP_DIV_NUM;
        state_nxt = osms_pkg::S_DNUM_W;
      end
      osms_pkg::S_DNUM_W: begin
        if (sts.div_done) state_nxt = osms_pkg::S_DQ;
      end
      osms_pkg::S_DQ: begin
        cmd.op    = osms_pkg::OP_DIV_Q;
        state_nxt = osms_pkg::S_DQ_W;
      end
      osms_pkg::S_DQ_W: begin
        if (sts.div_done) state_nxt = osms_pkg::S_DEN;
      end
      osms_pkg::S_DEN: begin
        cmd.op    = osms_pkg::OP_DEN;
        state_nxt = osms_pkg::S_DOM;
      end
      osms_pkg::S_DOM: begin
        cmd.op    = osms_pkg::OP_DIV_OMEGA;
        state_nxt = osms_pkg::S_DOM_W;
      end
      osms_pkg::S_DOM_W: begin
        if (sts.div_done) state_nxt = osms_pkg::S_UPDATE;
      end
      osms_pkg::S_UPDATE: begin
        cmd.op    = osms_pkg::OP_UPDATE;
        state_nxt = sts.last ? osms_pkg::S_EMIT : osms_pkg::S_IDLE;
      end
      osms_pkg::S_EMIT: begin
        if (sts.out_free) begin
          cmd.op    = osms_pkg::OP_EMIT;
          state_nxt = osms_pkg::S_IDLE;
        end
      end
      default: state_nxt = osms_pkg::S_IDLE;
    endcase
  end

  a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == osms_pkg::OP_DIV_NUM || cmd.op == osms_pkg::OP_DIV_Q ||
     cmd.op == osms_pkg::OP_DIV_OMEGA) |-> !sts.div_busy)
    else $error("divider started while busy");
  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.op == osms_pkg::OP_EMIT |-> sts.out_free)
    else $error("result overwritten before transfer");
  a_load_next: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> state_r == osms_pkg::S_FILT)
    else $error("accepted item not processed");

endmodule
`default_nettype wire

// File: rtl/core/omega_statistic_max_search.sv
// Top level: omega statistic maximum search over runs of window splits.
// A filtered item ends after the border check; a kept item goes through three multiplies
//   and then three divisions on the shared bit-serial divider.
// Throughput: one item at a time; the next transfer is taken once the item finishes.
// A result waits in an output register while further items are taken.
// Reset (rst_n, synchronous, low): offset 1, tolerance 0, running maximum cleared.
`default_nettype none
module omega_statistic_max_search #(
  parameter int SNP_INDEX_BITS = osms_pkg::SNP_INDEX_BITS,
  parameter int SUM_BITS       = osms_pkg::SUM_BITS,
  localparam int IN_W  = ((3 * SUM_BITS + 3 * SNP_INDEX_BITS + 7) / 8) * 8,
  localparam int OUT_W = ((SUM_BITS + 2 * SNP_INDEX_BITS + 7) / 8) * 8
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               cfg_wr_en,
  input  wire logic [osms_pkg::CFG_ADDR_BITS-1:0] cfg_addr,
  input  wire logic [osms_pkg::CFG_DATA_BITS-1:0] cfg_wdata,
  input  wire logic                               in_tvalid,
  output logic                                    in_tready,
  // left_sum, right_sum, total_sum, left_snp, center_snp, right_snp
  input  wire logic [IN_W-1:0]                    in_tdata,
  input  wire logic                               in_tlast,
  output logic                                    out_tvalid,
  input  wire logic                               out_tready,
  // max_omega, best_left_snp, best_right_snp
  output logic [OUT_W-1:0]                        out_tdata,
  // saturated
  output logic [0:0]                              out_tuser
);

  localparam int NW = SNP_INDEX_BITS;
  localparam int SW = SUM_BITS;

  osms_pkg::cmd_t    cmd;
  osms_pkg::status_t sts;
  logic [SW-1:0]     max_omega;
  logic [NW-1:0]     best_left_snp, best_right_snp;
  logic              saturated;

  osms_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(in_tvalid),
    .in_ready(in_tready),
    .sts     (sts),
    .cmd     (cmd)
  );

  osms_datapath #(
    .SNP_INDEX_BITS(SNP_INDEX_BITS),
    .SUM_BITS      (SUM_BITS)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .sts           (sts),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_addr      (cfg_addr),
    .cfg_wdata     (cfg_wdata),
    .left_sum      (in_tdata[SW-1:0]),
    .right_sum     (in_tdata[2*SW-1:SW]),
    .total_sum     (in_tdata[3*SW-1:2*SW]),
    .left_snp      (in_tdata[3*SW+NW-1:3*SW]),
    .center_snp    (in_tdata[3*SW+2*NW-1:3*SW+NW]),
    .right_snp     (in_tdata[3*SW+3*NW-1:3*SW+2*NW]),
    .last_pair     (in_tlast),
    .out_valid     (out_tvalid),
    .out_ready     (out_tready),
    .max_omega     (max_omega),
    .best_left_snp (best_left_snp),
    .best_right_snp(best_right_snp),
    .saturated     (saturated)
  );

  assign out_tdata = OUT_W'({best_right_snp, best_left_snp, max_omega});
  assign out_tuser = saturated;

endmodule
`default_nettype wire
